### rtl/core/pdwa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pdwa_pkg;

    localparam int COUNT_BITS    = 16;
    localparam int MAX_WINDOW    = 4096;
    localparam int DUTY_BITS     = 16;

    localparam int NUM_CH        = 4;
    localparam int NUM_SUMS      = 2 * NUM_CH;
    localparam int SUM_BITS      = 30;
    localparam int WIN_BITS      = 13;
    localparam int CORR_BITS     = 11;
    localparam int CFG_DATA_BITS = 13;
    localparam int CFG_ADDR_BITS = 2;

    localparam int CNT_BITS      = $clog2(MAX_WINDOW + 1);
    localparam int PROD_BITS     = CORR_BITS + CNT_BITS + 1;
    localparam int CSUM_BITS     = SUM_BITS + 2;
    localparam int TOT_BITS      = SUM_BITS + 1;
    localparam int REM_BITS      = TOT_BITS + 1;
    localparam int CH_BITS       = $clog2(NUM_CH);
    localparam int STEP_BITS     = $clog2(DUTY_BITS);
    localparam int SIDX_BITS     = CH_BITS + 1;

    localparam logic [WIN_BITS-1:0] WINDOW_RESET = WIN_BITS'(1024);
    localparam logic [SUM_BITS-1:0] SUM_LIMIT    = '1;

    typedef logic [CFG_ADDR_BITS-1:0] cfg_addr_t;

    localparam cfg_addr_t REG_WINDOW_SAMPLES  = CFG_ADDR_BITS'(0);
    localparam cfg_addr_t REG_HIGH_CORRECTION = CFG_ADDR_BITS'(1);
    localparam cfg_addr_t REG_LOW_CORRECTION  = CFG_ADDR_BITS'(2);

    localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(DUTY_BITS - 1);
    localparam logic [CH_BITS-1:0]   CH_LAST   = CH_BITS'(NUM_CH - 1);

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [DUTY_BITS-1:0]  duty_t;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_PROD,
        ST_LOAD,
        ST_DIV,
        ST_STORE,
        ST_PUBLISH
    } state_t;

    typedef struct packed {
        logic               accept;
        logic               prod_load;
        logic               chan_load;
        logic               div_step;
        logic               div_store;
        logic               publish;
        logic [CH_BITS-1:0] ch;
    } pdwa_cmd_t;

    typedef struct packed {
        logic close;
        logic out_free;
    } pdwa_status_t;

endpackage

`default_nettype wire

### rtl/core/pdwa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pdwa_ctrl
    import pdwa_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire pdwa_status_t status,
    output pdwa_cmd_t         cmd
);

    state_t                state_reg, state_next;
    logic [CH_BITS-1:0]    ch_reg, ch_next;
    logic [STEP_BITS-1:0]  step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
            ch_reg    <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        step_next  = '0;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.ch     = ch_reg;
        unique case (state_reg)
            ST_ACCUM:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.close)
                    begin
                        state_next = ST_PROD;
                    end
                end
            end
            ST_PROD:
            begin
                cmd.prod_load = 1'b1;
                ch_next       = '0;
                state_next    = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.chan_load = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_BITS'(1);
                if (step_reg == STEP_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.div_store = 1'b1;
                if (ch_reg == CH_LAST)
                begin
                    state_next = ST_PUBLISH;
                end
                else
                begin
                    ch_next    = ch_reg + CH_BITS'(1);
                    state_next = ST_LOAD;
                end
            end
            ST_PUBLISH:
            begin
                if (status.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/pdwa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module pdwa_datapath
    import pdwa_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire cfg_addr_t                cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  wire count_t                   counts [NUM_SUMS],
    input  wire pdwa_cmd_t                cmd,
    output pdwa_status_t                  status,
    input  wire logic                     out_ready,
    output logic                          out_valid,
    output duty_t                         duty [NUM_CH]
);

    logic [WIN_BITS-1:0]         win_reg;
    logic [CORR_BITS-1:0]        hcorr_reg;
    logic [CORR_BITS-1:0]        lcorr_reg;
    logic [SUM_BITS-1:0]         sums_reg [NUM_SUMS];
    logic [CNT_BITS-1:0]         cnt_reg;
    logic signed [PROD_BITS-1:0] hprod_reg;
    logic signed [PROD_BITS-1:0] lprod_reg;
    logic [TOT_BITS-1:0]         rem_reg;
    logic [TOT_BITS-1:0]         tot_reg;
    duty_t                       quo_reg;
    logic                        zero_reg;
    logic                        full_reg;
    duty_t                       dq_reg [NUM_CH];
    duty_t                       duty_reg [NUM_CH];
    logic                        out_valid_reg;

    logic [CNT_BITS-1:0]         win_eff;
    logic [CNT_BITS:0]           cnt_inc;
    logic [SUM_BITS-1:0]         hi_c;
    logic [SUM_BITS-1:0]         lo_c;
    logic [TOT_BITS-1:0]         total;
    logic [REM_BITS-1:0]         r2;
    logic [REM_BITS-1:0]         diff;
    logic [SIDX_BITS-1:0]        hi_idx;
    logic [SIDX_BITS-1:0]        lo_idx;

    function automatic logic [SUM_BITS-1:0] correct_sum(
        input logic [SUM_BITS-1:0]         sum,
        input logic signed [PROD_BITS-1:0] prod
    );
        logic signed [CSUM_BITS-1:0] s;
        logic [SUM_BITS-1:0]         r;
        s = $signed({2'b00, sum}) + CSUM_BITS'(prod);
        if (s[CSUM_BITS-1])
        begin
            r = '0;
        end
        else if (s[CSUM_BITS-2:SUM_BITS] != '0)
        begin
            r = SUM_LIMIT;
        end
        else
        begin
            r = s[SUM_BITS-1:0];
        end
        return r;
    endfunction

    function automatic logic [SUM_BITS-1:0] sat_add(
        input logic [SUM_BITS-1:0] sum,
        input count_t              cnt
    );
        logic [SUM_BITS:0]   s;
        logic [SUM_BITS-1:0] r;
        s = {1'b0, sum} + (SUM_BITS + 1)'(cnt);
        r = s[SUM_BITS] ? SUM_LIMIT : s[SUM_BITS-1:0];
        return r;
    endfunction

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= WINDOW_RESET;
            hcorr_reg <= '0;
            lcorr_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_WINDOW_SAMPLES:  win_reg   <= cfg_wdata[WIN_BITS-1:0];
                REG_HIGH_CORRECTION: hcorr_reg <= cfg_wdata[CORR_BITS-1:0];
                REG_LOW_CORRECTION:  lcorr_reg <= cfg_wdata[CORR_BITS-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        if (win_reg == '0)
        begin
            win_eff = CNT_BITS'(1);
        end
        else if (32'(win_reg) > MAX_WINDOW)
        begin
            win_eff = CNT_BITS'(MAX_WINDOW);
        end
        else
        begin
            win_eff = CNT_BITS'(win_reg);
        end
    end

    assign cnt_inc         = {1'b0, cnt_reg} + (CNT_BITS + 1)'(1);
    assign status.close    = cnt_inc >= {1'b0, win_eff};
    assign status.out_free = !out_valid_reg || out_ready;

    // running sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SUMS; i++)
            begin
                sums_reg[i] <= '0;
            end
            cnt_reg <= '0;
        end
        else if (cmd.accept)
        begin
            for (int i = 0; i < NUM_SUMS; i++)
            begin
                sums_reg[i] <= sat_add(sums_reg[i], counts[i]);
            end
            cnt_reg <= cnt_inc[CNT_BITS-1:0];
        end
        else if (cmd.publish)
        begin
            for (int i = 0; i < NUM_SUMS; i++)
            begin
                sums_reg[i] <= '0;
            end
            cnt_reg <= '0;
        end
    end

    assign hi_idx = {cmd.ch, 1'b0};
    assign lo_idx = {cmd.ch, 1'b1};
    assign hi_c   = correct_sum(sums_reg[hi_idx], hprod_reg);
    assign lo_c   = correct_sum(sums_reg[lo_idx], lprod_reg);
    assign total  = {1'b0, hi_c} + {1'b0, lo_c};
    assign r2     = {rem_reg, 1'b0};
    assign diff   = r2 - {1'b0, tot_reg};

    // correction products and fractional divider, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.prod_load)
        begin
            hprod_reg <= PROD_BITS'($signed(hcorr_reg)) * PROD_BITS'($signed({1'b0, cnt_reg}));
            lprod_reg <= PROD_BITS'($signed(lcorr_reg)) * PROD_BITS'($signed({1'b0, cnt_reg}));
        end
        if (cmd.chan_load)
        begin
            rem_reg  <= {1'b0, hi_c};
            tot_reg  <= total;
            quo_reg  <= '0;
            zero_reg <= total == '0;
            full_reg <= (lo_c == '0) && (hi_c != '0);
        end
        else if (cmd.div_step)
        begin
            if (r2 >= {1'b0, tot_reg})
            begin
                rem_reg <= diff[TOT_BITS-1:0];
                quo_reg <= {quo_reg[DUTY_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= r2[TOT_BITS-1:0];
                quo_reg <= {quo_reg[DUTY_BITS-2:0], 1'b0};
            end
        end
        if (cmd.div_store)
        begin
            if (zero_reg)
            begin
                dq_reg[cmd.ch] <= '0;
            end
            else if (full_reg)
            begin
                dq_reg[cmd.ch] <= '1;
            end
            else
            begin
                dq_reg[cmd.ch] <= quo_reg;
            end
        end
        if (cmd.publish)
        begin
            duty_reg <= dq_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign duty      = duty_reg;

endmodule

`default_nettype wire

### rtl/core/pwm_duty_window_average_core.sv
// Windowed duty measurement for four PWM channels (lx, ly, rx, ry).
// Input channel (in_valid/in_ready): one high and one low count per channel
// per transfer; counts are added into eight saturating 30-bit sums.
// Output channel (out_valid/out_ready): one transfer per window carrying the
// four duties high/(high+low) in unsigned Q0.16, floored, saturated at 65535.
// Config port: cfg_we/cfg_addr/cfg_wdata; 0 window_samples, 1 high_correction,
// 2 low_correction. Write only while idle.
// Throughput: one input transfer per cycle inside a window. The transfer that
// closes a window starts the correction and a shared radix-2 divider, one
// quotient bit per cycle; the channels are loaded, divided and stored in
// turn, and in_ready stays low until the new result is published.
// If the previous result is still unread at the end, the block holds the new
// result (and in_ready low) until the output register frees up.
// Reset: sums and sample count clear, window_samples 1024, corrections 0,
// out_valid low.
`timescale 1ns / 1ps
`default_nettype none

module pwm_duty_window_average_core
    import pdwa_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [COUNT_BITS-1:0]    lx_high_count,
    input  wire logic [COUNT_BITS-1:0]    lx_low_count,
    input  wire logic [COUNT_BITS-1:0]    ly_high_count,
    input  wire logic [COUNT_BITS-1:0]    ly_low_count,
    input  wire logic [COUNT_BITS-1:0]    rx_high_count,
    input  wire logic [COUNT_BITS-1:0]    rx_low_count,
    input  wire logic [COUNT_BITS-1:0]    ry_high_count,
    input  wire logic [COUNT_BITS-1:0]    ry_low_count,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [DUTY_BITS-1:0]          lx_duty,
    output logic [DUTY_BITS-1:0]          ly_duty,
    output logic [DUTY_BITS-1:0]          rx_duty,
    output logic [DUTY_BITS-1:0]          ry_duty
);

    pdwa_cmd_t    cmd;
    pdwa_status_t status;
    count_t       counts [NUM_SUMS];
    duty_t        duty [NUM_CH];

    assign counts[0] = lx_high_count;
    assign counts[1] = lx_low_count;
    assign counts[2] = ly_high_count;
    assign counts[3] = ly_low_count;
    assign counts[4] = rx_high_count;
    assign counts[5] = rx_low_count;
    assign counts[6] = ry_high_count;
    assign counts[7] = ry_low_count;

    assign lx_duty = duty[0];
    assign ly_duty = duty[1];
    assign rx_duty = duty[2];
    assign ry_duty = duty[3];

    pdwa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pdwa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .counts    (counts),
        .cmd       (cmd),
        .status    (status),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .duty      (duty)
    );

`ifndef SYNTHESIS
    a_publish_sets_valid: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.publish |=> out_valid
    ) else $error("publish did not raise out_valid");

    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid || out_ready)
    ) else $error("unread result overwritten");

    a_close_stalls_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && status.close) |=> !in_ready
    ) else $error("input taken while window result pending");
`endif

endmodule

`default_nettype wire
